/* hdl/lrn_pkg.sv */
// Shared types, register codes and constant tables for the cross-channel LRN block.
package lrn_pkg;

	localparam int MAX_WINDOW   = 15;
	localparam int MAX_CHANNELS = 1024;
	localparam int DATA_BITS    = 16;
	localparam int CH_W         = 11;
	localparam int WIN_W        = $clog2(MAX_WINDOW);
	localparam int HALF_MAX     = (MAX_WINDOW - 1) / 2;
	localparam int HALF_W       = $clog2(HALF_MAX + 1);
	localparam int SQ_W         = 2 * DATA_BITS;
	localparam int SUM_W        = SQ_W + WIN_W;
	localparam int PADDR_W      = 5;

	localparam logic [2:0] REG_NUM_CHANNELS = 3'd0;
	localparam logic [2:0] REG_WINDOW_SIZE  = 3'd1;
	localparam logic [2:0] REG_ALPHA        = 3'd2;
	localparam logic [2:0] REG_BETA         = 3'd3;
	localparam logic [2:0] REG_BIAS         = 3'd4;

	typedef struct packed {
		logic [23:0] alpha;
		logic [15:0] beta;
		logic [23:0] bias;
	} norm_cfg_t;

	typedef struct packed {
		logic signed [DATA_BITS-1:0] sample;
		logic [SQ_W-1:0]             square;
	} cell_data_t;

	typedef struct packed {
		logic shift;
		logic rotate;
	} cell_ctl_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] b;
		rem = v;
		res = '0;
		b   = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + b) begin
				rem = rem - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// 2^(2^-k) in Q2.30, by successive truncated square roots
	function automatic logic [31:0] exp2_root(input int k);
		logic [63:0] r;
		r = 64'd2 << 30;
		for (int i = 1; i <= k; i++) begin
			r = isqrt64(r << 30);
		end
		return r[31:0];
	endfunction

	localparam logic [31:0] EXP2_ROOT [16] = '{
		exp2_root(1),  exp2_root(2),  exp2_root(3),  exp2_root(4),
		exp2_root(5),  exp2_root(6),  exp2_root(7),  exp2_root(8),
		exp2_root(9),  exp2_root(10), exp2_root(11), exp2_root(12),
		exp2_root(13), exp2_root(14), exp2_root(15), exp2_root(16)
	};

endpackage

/* hdl/lrn_cell.sv */
// One window cell: holds a sample and its square, shifts on a new request, rotates for summing.
module lrn_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  lrn_pkg::cell_ctl_t  ctl,
	input  lrn_pkg::cell_data_t shift_in,
	input  lrn_pkg::cell_data_t rot_in,
	output lrn_pkg::cell_data_t data
);
	import lrn_pkg::*;

	cell_data_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (ctl.shift) begin
			data_q <= shift_in;
		end else if (ctl.rotate) begin
			data_q <= rot_in;
		end
	end

	assign data = data_q;

endmodule

/* hdl/lrn_norm.sv */
// Iterative power unit: x * (bias + alpha*sum)^(-beta) via log2 squaring and exp2 root table.
module lrn_norm (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [lrn_pkg::DATA_BITS-1:0] x,
	input  logic [lrn_pkg::SUM_W-1:0]           sum,
	input  lrn_pkg::norm_cfg_t                   cfg,
	output logic                                busy,
	output logic                                done,
	output logic signed [lrn_pkg::DATA_BITS-1:0] result
);
	import lrn_pkg::*;

	typedef enum logic [3:0] {
		N_IDLE, N_MUL0, N_MUL1, N_FULL, N_BASE, N_NORMZ, N_LOG,
		N_EXP, N_CHK, N_POW, N_MAG, N_RND, N_SAT
	} nstate_t;

	localparam logic [47:0] MAXPOS = 48'((64'd1 << (DATA_BITS - 1)) - 1);

	nstate_t                     state_q;
	logic signed [DATA_BITS-1:0] x_q;
	logic                        neg_q;
	logic [DATA_BITS-1:0]        ax_q;
	logic [SUM_W-1:0]            sum_q;
	logic [41:0]                 plo_q;
	logic [41:0]                 phi_q;
	logic [59:0]                 full_q;
	logic [31:0]                 m_q;
	logic [4:0]                  pos_q;
	logic [15:0]                 frac_q;
	logic [3:0]                  it_q;
	logic signed [37:0]          e_q;
	logic [31:0]                 pw_q;
	logic [47:0]                 mag_q;
	logic                        done_q;
	logic signed [DATA_BITS-1:0] result_q;

	logic [31:0]        d;
	logic [61:0]        sq;
	logic [31:0]        t;
	logic signed [5:0]  lint;
	logic signed [21:0] lval;
	logic signed [38:0] bprod;
	logic signed [9:0]  ip;
	logic signed [10:0] s;
	logic [63:0]        pprod;
	logic [DATA_BITS-1:0] sat_big;
	logic [DATA_BITS-1:0] sat_mag;

	function automatic logic [DATA_BITS-1:0] saturate(input logic neg, input logic [47:0] mag);
		logic [47:0] lim;
		lim = neg ? MAXPOS + 48'd1 : MAXPOS;
		if (mag > lim) begin
			mag = lim;
		end
		return neg ? DATA_BITS'(-mag) : DATA_BITS'(mag);
	endfunction

	always_comb begin
		d     = {8'd0, cfg.bias} + {4'd0, full_q[59:32]};
		sq    = m_q[30:0] * m_q[30:0];
		t     = sq[61:30];
		lint  = $signed({1'b0, pos_q}) - 6'sd16;
		lval  = {lint, frac_q};
		bprod = $signed({1'b0, cfg.beta}) * lval;
		ip    = e_q[37:28];
		s     = 11'sd30 - 11'(ip);
		pprod = {32'd0, pw_q} * {32'd0, EXP2_ROOT[it_q]};
		sat_big = saturate(neg_q, '1);
		sat_mag = saturate(neg_q, mag_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				N_IDLE: begin
					if (start) begin
						x_q     <= x;
						neg_q   <= x[DATA_BITS-1];
						ax_q    <= x[DATA_BITS-1] ? DATA_BITS'(-x) : DATA_BITS'(x);
						sum_q   <= sum;
						state_q <= N_MUL0;
					end
				end
				N_MUL0: begin
					plo_q   <= 42'(cfg.alpha * sum_q[17:0]);
					state_q <= N_MUL1;
				end
				N_MUL1: begin
					phi_q   <= 42'(cfg.alpha * sum_q[SUM_W-1:18]);
					state_q <= N_FULL;
				end
				N_FULL: begin
					full_q  <= {phi_q, 18'd0} + {18'd0, plo_q};
					state_q <= N_BASE;
				end
				N_BASE: begin
					if (cfg.beta == '0) begin
						result_q <= x_q;
						done_q   <= 1'b1;
						state_q  <= N_IDLE;
					end else if (d == '0) begin
						result_q <= (ax_q == '0) ? '0 : sat_big;
						done_q   <= 1'b1;
						state_q  <= N_IDLE;
					end else begin
						m_q     <= d;
						pos_q   <= 5'd30;
						state_q <= N_NORMZ;
					end
				end
				N_NORMZ: begin
					// walk the leading one up to bit 30 (Q1.30 mantissa)
					if (m_q[30]) begin
						it_q    <= '0;
						frac_q  <= '0;
						state_q <= N_LOG;
					end else begin
						m_q   <= m_q << 1;
						pos_q <= pos_q - 5'd1;
					end
				end
				N_LOG: begin
					frac_q <= {frac_q[14:0], t[31]};
					m_q    <= t[31] ? {1'b0, t[31:1]} : t;
					it_q   <= it_q + 4'd1;
					if (it_q == 4'd15) begin
						state_q <= N_EXP;
					end
				end
				N_EXP: begin
					e_q     <= 38'(-bprod);
					state_q <= N_CHK;
				end
				N_CHK: begin
					if (ax_q == '0) begin
						result_q <= '0;
						done_q   <= 1'b1;
						state_q  <= N_IDLE;
					end else if (ip >= 10'sd31) begin
						result_q <= sat_big;
						done_q   <= 1'b1;
						state_q  <= N_IDLE;
					end else begin
						pw_q    <= 32'd1 << 30;
						it_q    <= '0;
						state_q <= N_POW;
					end
				end
				N_POW: begin
					// fraction bit of weight 2^-(it+1)
					if (e_q[5'd27 - 5'(it_q)]) begin
						pw_q <= pprod[61:30];
					end
					it_q <= it_q + 4'd1;
					if (it_q == 4'd15) begin
						state_q <= N_MAG;
					end
				end
				N_MAG: begin
					mag_q   <= 48'(ax_q * pw_q[30:0]);
					state_q <= N_RND;
				end
				N_RND: begin
					if (s >= 11'sd48) begin
						mag_q <= '0;
					end else if (s != 11'sd0) begin
						mag_q <= (mag_q + (48'd1 << (s[5:0] - 6'd1))) >> s[5:0];
					end
					state_q <= N_SAT;
				end
				N_SAT: begin
					result_q <= sat_mag;
					done_q   <= 1'b1;
					state_q  <= N_IDLE;
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != N_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

/* hdl/lrn_across_channels.sv */
// Top level: register port, window cell chain, result sequencer and output register.
//
//  channel  | direction | handshake           | payload
//  in       | request   | in_valid / in_stall | in_value
//  out      | result    | out_valid/out_stall | out_value, out_channel_last
//  config   | APB write | psel/penable/pwrite | paddr, pwdata, prdata
//
// A sample enters the chain when accepted; each result it releases then takes a check,
// a rotation of the 15-cell chain for the window sum, the power unit (leading-one walk,
// 16 log squarings, 16 exp2 products; ending early when beta or the base is zero, or for
// a zero sample or an overflowing exponent) and a hand-over to the output register.
// The last channel of a position releases up to half+1 results in turn.
// Reset sets the configuration registers to their defaults and empties the window; no clearing pass.
// in_stall is high while the results of a sample are being formed; a stalled
// output holds its register and the sequencer waits for it.
module lrn_across_channels (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [lrn_pkg::DATA_BITS-1:0] in_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [lrn_pkg::DATA_BITS-1:0] out_value,
	output logic                                out_channel_last,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [lrn_pkg::PADDR_W-1:0]          paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                pready
);
	import lrn_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_CHECK, S_SUM, S_GO, S_NORM, S_OUT} state_t;

	logic [CH_W-1:0] num_ch_q;
	logic [3:0]      win_q;
	norm_cfg_t       cfg_q;

	state_t                      state_q;
	logic [CH_W-1:0]             chan_q;
	logic [CH_W-1:0]             emit_q;
	logic                        last_q;
	logic [WIN_W-1:0]            j_q;
	logic [WIN_W-1:0]            klo_q;
	logic [WIN_W-1:0]            khi_q;
	logic [WIN_W-1:0]            t_q;
	logic [SUM_W-1:0]            acc_q;
	logic signed [DATA_BITS-1:0] xs_q;
	logic signed [DATA_BITS-1:0] res_q;
	logic                        out_valid_q;
	logic signed [DATA_BITS-1:0] out_value_q;
	logic                        out_last_q;

	logic                        cfg_wr;
	logic [2:0]                  cfg_idx;
	logic [CH_W-1:0]             nch_eff;
	logic [CH_W-1:0]             last_ch;
	logic [HALF_W-1:0]           half;
	logic                        accept;
	logic                        emit_ok;
	logic [CH_W-1:0]             jv;
	logic [WIN_W-1:0]            jvh;
	logic                        in_range;
	logic                        norm_busy;
	logic                        norm_done;
	logic signed [DATA_BITS-1:0] norm_result;

	cell_ctl_t  ctl;
	cell_data_t new_cell;
	cell_data_t chain [MAX_WINDOW];

	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[4:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_ch_q    <= CH_W'(64);
			win_q       <= 4'd5;
			cfg_q.alpha <= 24'd1677;
			cfg_q.beta  <= 16'd3072;
			cfg_q.bias  <= 24'd65536;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_NUM_CHANNELS: num_ch_q    <= pwdata[CH_W-1:0];
				REG_WINDOW_SIZE:  win_q       <= pwdata[3:0];
				REG_ALPHA:        cfg_q.alpha <= pwdata[23:0];
				REG_BETA:         cfg_q.beta  <= pwdata[15:0];
				REG_BIAS:         cfg_q.bias  <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_NUM_CHANNELS: prdata = {21'd0, num_ch_q};
			REG_WINDOW_SIZE:  prdata = {28'd0, win_q};
			REG_ALPHA:        prdata = {8'd0, cfg_q.alpha};
			REG_BETA:         prdata = {16'd0, cfg_q.beta};
			REG_BIAS:         prdata = {8'd0, cfg_q.bias};
			default:          prdata = '0;
		endcase
	end

	always_comb begin
		if (num_ch_q == '0) begin
			nch_eff = CH_W'(1);
		end else if (num_ch_q > CH_W'(MAX_CHANNELS)) begin
			nch_eff = CH_W'(MAX_CHANNELS);
		end else begin
			nch_eff = num_ch_q;
		end
		last_ch = nch_eff - CH_W'(1);
		half    = (win_q[3:1] > HALF_W'(HALF_MAX)) ? HALF_W'(HALF_MAX) : HALF_W'(win_q[3:1]);
		accept  = in_valid && !in_stall;
		emit_ok = (emit_q <= chan_q) &&
			((emit_q + CH_W'(half) <= chan_q) || last_q);
		jv      = chan_q - emit_q;
		jvh     = jv[WIN_W-1:0] + WIN_W'(half);
		in_range = (t_q >= klo_q) && (t_q <= khi_q);
		ctl.shift  = accept;
		ctl.rotate = (state_q == S_SUM);
		new_cell.sample = in_value;
		new_cell.square = $unsigned(SQ_W'(in_value * in_value));
	end

	// cell 0 holds the newest channel; rotating brings each cell to cell 0 in turn
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		lrn_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.shift_in ((i == 0) ? new_cell : chain[(i + MAX_WINDOW - 1) % MAX_WINDOW]),
			.rot_in   (chain[(i + 1) % MAX_WINDOW]),
			.data     (chain[i])
		);
	end

	lrn_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_GO),
		.x      (xs_q),
		.sum    (acc_q),
		.cfg    (cfg_q),
		.busy   (norm_busy),
		.done   (norm_done),
		.result (norm_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			chan_q      <= '0;
			emit_q      <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q  <= (chan_q == last_ch);
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (emit_ok) begin
						j_q     <= jv[WIN_W-1:0];
						klo_q   <= (jv[WIN_W-1:0] > WIN_W'(half)) ?
							jv[WIN_W-1:0] - WIN_W'(half) : '0;
						khi_q   <= (chan_q < CH_W'(jvh)) ? chan_q[WIN_W-1:0] : jvh;
						t_q     <= '0;
						acc_q   <= '0;
						state_q <= S_SUM;
					end else begin
						if (last_q) begin
							chan_q <= '0;
							emit_q <= '0;
						end else begin
							chan_q <= chan_q + CH_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				S_SUM: begin
					if (in_range) begin
						acc_q <= acc_q + SUM_W'(chain[0].square);
					end
					if (t_q == j_q) begin
						xs_q <= chain[0].sample;
					end
					t_q <= t_q + WIN_W'(1);
					if (t_q == WIN_W'(MAX_WINDOW - 1)) begin
						state_q <= S_GO;
					end
				end
				S_GO: begin
					state_q <= S_NORM;
				end
				S_NORM: begin
					if (norm_done) begin
						res_q   <= norm_result;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_value_q <= res_q;
						out_last_q  <= (emit_q == last_ch);
						emit_q      <= emit_q + CH_W'(1);
						state_q     <= S_CHECK;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// any register write restarts the position
			if (cfg_wr && (cfg_idx <= REG_BIAS)) begin
				chan_q <= '0;
				emit_q <= '0;
			end
		end
	end

	assign in_stall         = (state_q != S_IDLE);
	assign out_valid        = out_valid_q;
	assign out_value        = out_value_q;
	assign out_channel_last = out_last_q;

	a_emit_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (emit_q <= chan_q))
		else $error("emit index ahead of channel index");

	a_centre_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUM) |-> (j_q <= WIN_W'(half)))
		else $error("window centre outside half window");

	a_norm_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GO) |-> !norm_busy)
		else $error("power unit started while busy");

	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		norm_done |-> (state_q == S_NORM))
		else $error("power unit result with no request waiting");

endmodule
